// ===== src/ppi_pkg.sv =====
// Shared widths, sideband word types and the saturating offset add for the
// parabolic peak interpolator. No dependencies.
package ppi_pkg;

   localparam int X_W   = 32;   // input coordinate
   localparam int D_W   = 33;   // xi - xj
   localparam int E_W   = 34;   // d01 - d12
   localparam int P_W   = 65;   // y * d
   localparam int SQ_W  = 66;   // d * d
   localparam int DE_W  = 67;   // d02 * e
   localparam int A_W   = 67;   // curvature numerator
   localparam int BT_W  = 98;   // y * d^2
   localparam int BM_W  = 99;   // y1 * d02 * e
   localparam int DD_W  = 99;   // d01 * d02 * d12
   localparam int B_W   = 101;  // slope numerator
   localparam int BB_W  = 202;  // B * B
   localparam int AD_W  = 166;  // A * D
   localparam int NX_W  = 103;  // 2|B| + 2|A|
   localparam int DX_W  = 69;   // 4|A|
   localparam int NY_W  = 204;  // 2B^2 + 4|AD|
   localparam int DY_W  = 169;  // 8|AD|
   localparam int Q_W   = 33;   // quotient bits kept, larger saturates
   localparam int S_W   = Q_W + 2;

   localparam int MUL1_NS = 2;
   localparam int MUL2_NS = 3;
   localparam int MUL3_NS = 10;

   localparam logic [X_W-1:0] X_MAX = {1'b0, {(X_W-1){1'b1}}};
   localparam logic [X_W-1:0] X_MIN = {1'b1, {(X_W-1){1'b0}}};

   typedef struct packed {
      logic                  eq;
      logic signed [X_W-1:0] x1;
      logic signed [X_W-1:0] y0;
      logic signed [X_W-1:0] y1;
      logic signed [X_W-1:0] y2;
      logic signed [D_W-1:0] d12;
   } tag1_type;

   typedef struct packed {
      logic                  flat;
      logic signed [X_W-1:0] x1;
      logic signed [X_W-1:0] y1;
      logic signed [A_W-1:0] a;
   } tag2_type;

   typedef struct packed {
      logic                  flat;
      logic signed [X_W-1:0] x1;
      logic signed [X_W-1:0] y1;
      logic                  negx;
      logic [NX_W-1:0]       numx;
      logic [DX_W-1:0]       denx;
   } tag3_type;

   typedef struct packed {
      logic                  flat;
      logic signed [X_W-1:0] x1;
      logic signed [X_W-1:0] y1;
      logic                  negx;
      logic                  negy;
   } tag4_type;

   typedef struct packed {
      logic [X_W-1:0] value;
      logic           sat;
   } sat_res_type;

   function automatic sat_res_type sat_add(input logic signed [X_W-1:0] base,
                                           input logic [Q_W-1:0] q,
                                           input logic neg,
                                           input logic big);
      sat_res_type           r;
      logic signed [S_W-1:0] v;
      logic                  in_range;
      v = neg ? (S_W'(base) - $signed({2'b00, q})) : (S_W'(base) + $signed({2'b00, q}));
      in_range = (&v[S_W-1:X_W-1]) | ~(|v[S_W-1:X_W-1]);
      if (big) begin
         r.value = neg ? X_MIN : X_MAX;
         r.sat   = 1'b1;
      end else if (!in_range) begin
         r.value = v[S_W-1] ? X_MIN : X_MAX;
         r.sat   = 1'b1;
      end else begin
         r.value = v[X_W-1:0];
         r.sat   = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== src/parabolic_peak_interpolator.sv =====
// Top level: three-point parabolic vertex fit over three multiplier layers
// and two parallel dividers. Uses ppi_pkg, ppi_mul, ppi_div.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_tvalid/tready  | tdata: six Q16.16 coordinates
//  rsp     | out       | rsp_tvalid/tready  | tdata: peak x, y; tuser: flags
//
// One word accepted per cycle unless rsp stalls; the depth is set by the 33
// quotient steps of the dividers and the chunked multiplier stages.
// Synchronous reset clears the valid bits only.
// A stall on rsp freezes the whole pipeline; req_tready drops with it.
module parabolic_peak_interpolator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point0_x, point0_y, point1_x, point1_y, point2_x, point2_y
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // peak_x, peak_y
   output logic [63:0]  rsp_tdata,
   // flat_flag, saturated
   output logic [1:0]   rsp_tuser
);
   import ppi_pkg::*;

   logic en;
   logic s0_valid_ff;
   logic [6*X_W-1:0] s0_data_ff;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
      if (en) begin
         s0_data_ff <= req_tdata;
      end
   end

   // differences
   logic signed [X_W-1:0] x0, y0, x1, y1, x2, y2;
   logic signed [D_W-1:0] d01, d02, d12;
   logic signed [E_W-1:0] e;
   tag1_type tag1, t1;

   assign x0   = $signed(s0_data_ff[0*X_W +: X_W]);
   assign y0   = $signed(s0_data_ff[1*X_W +: X_W]);
   assign x1   = $signed(s0_data_ff[2*X_W +: X_W]);
   assign y1   = $signed(s0_data_ff[3*X_W +: X_W]);
   assign x2   = $signed(s0_data_ff[4*X_W +: X_W]);
   assign y2   = $signed(s0_data_ff[5*X_W +: X_W]);
   assign d01  = D_W'(x0) - D_W'(x1);
   assign d02  = D_W'(x0) - D_W'(x2);
   assign d12  = D_W'(x1) - D_W'(x2);
   assign e    = E_W'(d01) - E_W'(d12);
   assign tag1 = '{eq: (x0 == x1) || (x0 == x2) || (x1 == x2),
                   x1: x1, y0: y0, y1: y1, y2: y2, d12: d12};

   // layer 1
   logic                   v1;
   logic signed [SQ_W-1:0] d12sq, d01sq, d0102;
   logic signed [DE_W-1:0] d02e;
   logic signed [P_W-1:0]  a0, a1, a2;

   ppi_mul #(.AW(D_W), .BW(D_W), .NS(MUL1_NS), .TW($bits(tag1_type))) u_m_d12sq (
      .clock, .reset, .en, .in_valid(s0_valid_ff), .a(d12), .b(d12), .tag_i(tag1),
      .out_valid(v1), .p(d12sq), .tag_o(t1));
   ppi_mul #(.AW(D_W), .BW(D_W), .NS(MUL1_NS)) u_m_d01sq (
      .clock, .reset, .en, .in_valid(s0_valid_ff), .a(d01), .b(d01), .tag_i(1'b0),
      .out_valid(), .p(d01sq), .tag_o());
   ppi_mul #(.AW(D_W), .BW(E_W), .NS(MUL1_NS)) u_m_d02e (
      .clock, .reset, .en, .in_valid(s0_valid_ff), .a(d02), .b(e), .tag_i(1'b0),
      .out_valid(), .p(d02e), .tag_o());
   ppi_mul #(.AW(D_W), .BW(D_W), .NS(MUL1_NS)) u_m_d0102 (
      .clock, .reset, .en, .in_valid(s0_valid_ff), .a(d01), .b(d02), .tag_i(1'b0),
      .out_valid(), .p(d0102), .tag_o());
   ppi_mul #(.AW(X_W), .BW(D_W), .NS(MUL1_NS)) u_m_a0 (
      .clock, .reset, .en, .in_valid(s0_valid_ff), .a(y0), .b(d12), .tag_i(1'b0),
      .out_valid(), .p(a0), .tag_o());
   ppi_mul #(.AW(X_W), .BW(D_W), .NS(MUL1_NS)) u_m_a1 (
      .clock, .reset, .en, .in_valid(s0_valid_ff), .a(y1), .b(d02), .tag_i(1'b0),
      .out_valid(), .p(a1), .tag_o());
   ppi_mul #(.AW(X_W), .BW(D_W), .NS(MUL1_NS)) u_m_a2 (
      .clock, .reset, .en, .in_valid(s0_valid_ff), .a(y2), .b(d01), .tag_i(1'b0),
      .out_valid(), .p(a2), .tag_o());

   // curvature numerator
   logic signed [A_W-1:0] a_sum;
   tag2_type tag2, t2;

   assign a_sum = A_W'(a0) - A_W'(a1) + A_W'(a2);
   assign tag2  = '{flat: t1.eq || (a_sum == '0), x1: t1.x1, y1: t1.y1, a: a_sum};

   // layer 2
   logic                   v2;
   logic signed [BT_W-1:0] b0, b2;
   logic signed [BM_W-1:0] b1;
   logic signed [DD_W-1:0] dd;

   ppi_mul #(.AW(SQ_W), .BW(X_W), .NS(MUL2_NS), .TW($bits(tag2_type))) u_m_b0 (
      .clock, .reset, .en, .in_valid(v1), .a(d12sq), .b(t1.y0), .tag_i(tag2),
      .out_valid(v2), .p(b0), .tag_o(t2));
   ppi_mul #(.AW(SQ_W), .BW(X_W), .NS(MUL2_NS)) u_m_b2 (
      .clock, .reset, .en, .in_valid(v1), .a(d01sq), .b(t1.y2), .tag_i(1'b0),
      .out_valid(), .p(b2), .tag_o());
   ppi_mul #(.AW(DE_W), .BW(X_W), .NS(MUL2_NS)) u_m_b1 (
      .clock, .reset, .en, .in_valid(v1), .a(d02e), .b(t1.y1), .tag_i(1'b0),
      .out_valid(), .p(b1), .tag_o());
   ppi_mul #(.AW(SQ_W), .BW(D_W), .NS(MUL2_NS)) u_m_dd (
      .clock, .reset, .en, .in_valid(v1), .a(d0102), .b(t1.d12), .tag_i(1'b0),
      .out_valid(), .p(dd), .tag_o());

   // slope numerator, x quotient operands
   logic signed [B_W-1:0] b_sum;
   logic [B_W-1:0]        abs_b;
   logic [A_W-1:0]        abs_a;
   tag3_type tag3, t3;

   assign b_sum = B_W'(b0) - B_W'(b2) + B_W'(b1);
   assign abs_b = b_sum[B_W-1] ? B_W'(-b_sum) : B_W'(b_sum);
   assign abs_a = t2.a[A_W-1] ? A_W'(-t2.a) : A_W'(t2.a);
   assign tag3  = '{flat: t2.flat, x1: t2.x1, y1: t2.y1,
                    negx: b_sum[B_W-1] == t2.a[A_W-1],
                    numx: NX_W'({abs_b, 1'b0}) + NX_W'({abs_a, 1'b0}),
                    denx: {abs_a, 2'b00}};

   // layer 3
   logic                   v3;
   logic signed [BB_W-1:0] bb;
   logic signed [AD_W-1:0] ad;

   ppi_mul #(.AW(B_W), .BW(B_W), .NS(MUL3_NS), .TW($bits(tag3_type))) u_m_bb (
      .clock, .reset, .en, .in_valid(v2), .a(b_sum), .b(b_sum), .tag_i(tag3),
      .out_valid(v3), .p(bb), .tag_o(t3));
   ppi_mul #(.AW(A_W), .BW(DD_W), .NS(MUL3_NS)) u_m_ad (
      .clock, .reset, .en, .in_valid(v2), .a(t2.a), .b(dd), .tag_i(1'b0),
      .out_valid(), .p(ad), .tag_o());

   // y quotient operands
   logic [AD_W-1:0] abs_ad;
   logic [NY_W-1:0] numy;
   logic [DY_W-1:0] deny;
   tag4_type tag4, t4;

   assign abs_ad = ad[AD_W-1] ? AD_W'(-ad) : AD_W'(ad);
   assign numy   = NY_W'({bb, 1'b0}) + NY_W'({abs_ad, 2'b00});
   assign deny   = {abs_ad, 3'b000};
   assign tag4   = '{flat: t3.flat, x1: t3.x1, y1: t3.y1, negx: t3.negx,
                     negy: ~ad[AD_W-1]};

   // dividers
   logic           vx, vy, bigx, bigy;
   logic [Q_W-1:0] qx, qy;

   ppi_div #(.NW(NX_W), .DW(DX_W), .QW(Q_W), .TW($bits(tag4_type))) u_div_x (
      .clock, .reset, .en, .in_valid(v3), .num(t3.numx), .den(t3.denx), .tag_i(tag4),
      .out_valid(vx), .q(qx), .big(bigx), .tag_o(t4));
   ppi_div #(.NW(NY_W), .DW(DY_W), .QW(Q_W)) u_div_y (
      .clock, .reset, .en, .in_valid(v3), .num(numy), .den(deny), .tag_i(1'b0),
      .out_valid(vy), .q(qy), .big(bigy), .tag_o());

   // output register
   sat_res_type rx, ry;
   logic           rsp_tvalid_ff;
   logic [X_W-1:0] peak_x_ff, peak_y_ff;
   logic           flat_ff, sat_ff;

   assign rx = sat_add(t4.x1, qx, t4.negx, bigx);
   assign ry = sat_add(t4.y1, qy, t4.negy, bigy);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= vx;
      end
      if (en) begin
         peak_x_ff <= t4.flat ? t4.x1 : rx.value;
         peak_y_ff <= t4.flat ? t4.y1 : ry.value;
         flat_ff   <= t4.flat;
         sat_ff    <= !t4.flat && (rx.sat || ry.sat);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {peak_y_ff, peak_x_ff};
   assign rsp_tuser  = {sat_ff, flat_ff};

   a_div_aligned : assert property (@(posedge clock) disable iff (reset) vx == vy)
      else $error("divider valids out of step");
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_tvalid_ff)
      else $error("output valid after reset");
   a_flat_no_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && flat_ff |-> !sat_ff)
      else $error("flat result marked saturated");
   a_sat_at_rail : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && sat_ff |->
         peak_x_ff == X_MAX || peak_x_ff == X_MIN || peak_y_ff == X_MAX || peak_y_ff == X_MIN)
      else $error("saturated word not at a rail");
endmodule

// ===== src/ppi_mul.sv =====
// Pipelined signed multiplier: one chunk of operand a per stage, exact product.
// No dependencies; sideband word rides along.
module ppi_mul #(
   parameter int AW = 33,
   parameter int BW = 33,
   parameter int NS = 2,
   parameter int TW = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   input  logic [TW-1:0]           tag_i,
   output logic                    out_valid,
   output logic signed [AW+BW-1:0] p,
   output logic [TW-1:0]           tag_o
);
   localparam int PW = AW + BW;
   localparam int CW = (AW + NS - 1) / NS;
   localparam int XW = CW * NS;

   logic [PW-1:0]        acc_ff [0:NS];
   logic [XW-1:0]        a_ff   [0:NS];
   logic signed [BW-1:0] b_ff   [0:NS];
   logic [TW-1:0]        tag_ff [0:NS];
   logic                 vld_ff [0:NS];
   logic [PW-1:0]        acc_in;

   // signed a = unsigned bits - sign * 2^AW
   assign acc_in = a[AW-1] ? (PW'(0) - (PW'(b) << AW)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
      if (en) begin
         acc_ff[0] <= acc_in;
         a_ff[0]   <= XW'({1'b0, a[AW-1:0]});
         b_ff[0]   <= b;
         tag_ff[0] <= tag_i;
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic signed [CW+BW:0] prod;
      logic [PW-1:0]         pp;
      assign prod = $signed({1'b0, a_ff[s][s*CW +: CW]}) * b_ff[s];
      assign pp   = PW'(prod) << (s * CW);
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (en) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (en) begin
            acc_ff[s+1] <= acc_ff[s] + pp;
            a_ff[s+1]   <= a_ff[s];
            b_ff[s+1]   <= b_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[NS];
   assign p         = $signed(acc_ff[NS]);
   assign tag_o     = tag_ff[NS];
endmodule

// ===== src/ppi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an up-front
// overflow check for quotients that do not fit QW bits. No dependencies.
module ppi_div #(
   parameter int NW = 103,
   parameter int DW = 69,
   parameter int QW = 33,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag_i,
   output logic          out_valid,
   output logic [QW-1:0] q,
   output logic          big,
   output logic [TW-1:0] tag_o
);
   localparam int WW = (NW > DW + QW) ? NW : DW + QW;

   logic [WW-1:0] rem_ff [0:QW];
   logic [DW-1:0] den_ff [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic          big_ff [0:QW];
   logic [TW-1:0] tag_ff [0:QW];
   logic          vld_ff [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0] <= WW'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         big_ff[0] <= WW'(num) >= (WW'(den) << QW);
         tag_ff[0] <= tag_i;
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [WW:0] trial;
      assign trial = {1'b0, rem_ff[i]} - {1'b0, (WW'(den_ff[i]) << (QW - 1 - i))};
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (en) begin
            rem_ff[i+1] <= trial[WW] ? rem_ff[i] : trial[WW-1:0];
            q_ff[i+1]   <= {q_ff[i][QW-2:0], ~trial[WW]};
            den_ff[i+1] <= den_ff[i];
            big_ff[i+1] <= big_ff[i];
            tag_ff[i+1] <= tag_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign q         = q_ff[QW];
   assign big       = big_ff[QW];
   assign tag_o     = tag_ff[QW];
endmodule
